FILE: design/ede_pkg.sv
`default_nettype none
package ede_pkg;

  localparam int MAX_REF_LEN = 64;
  localparam int DIST_W = 16;
  localparam int CHAR_W = 8;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_value;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              ref_overflow;
  } out_item_t;

  // Wavefront token moving from one cell to the next.
  typedef struct packed {
    logic              last;
    logic [CHAR_W-1:0] ch;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] res;
  } token_t;

  typedef struct packed {
    logic              adv;
    logic              restart;
    logic              wr;
    logic [CHAR_W-1:0] wr_char;
  } cell_ctl_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    sat_inc = (v == {DIST_W{1'b1}}) ? v : v + DIST_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: design/ede_head.sv
`default_nettype none
module ede_head #(
  parameter int LW = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ede_pkg::cell_ctl_t ctl,
  input  wire logic               q_vld,
  input  wire logic [ede_pkg::CHAR_W-1:0] q_ch,
  input  wire logic               q_last,
  input  wire logic [LW-1:0]      ref_len,
  output logic                    out_vld,
  output ede_pkg::token_t         out_tok
);

  logic                       vld_r;
  ede_pkg::token_t            tok_r;
  logic [ede_pkg::DIST_W-1:0] d_r;
  logic [ede_pkg::DIST_W-1:0] inc;
  ede_pkg::token_t            tok_nxt;

  always_comb begin
    inc = ede_pkg::sat_inc(d_r);
    tok_nxt.last = q_last;
    tok_nxt.ch = q_ch;
    tok_nxt.left = inc;
    tok_nxt.diag = d_r;
    tok_nxt.res = (ref_len == LW'(0)) ? inc : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      d_r <= '0;
    end else begin
      if (ctl.adv) begin
        vld_r <= q_vld;
      end
      if (ctl.restart) begin
        d_r <= '0;
      end else if (ctl.adv && q_vld) begin
        d_r <= q_last ? '0 : inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule
`default_nettype wire

FILE: design/ede_cell.sv
`default_nettype none
module ede_cell #(
  parameter int IDX = 1,
  parameter int LW  = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ede_pkg::cell_ctl_t ctl,
  input  wire logic [LW-1:0]      ref_len,
  input  wire logic               in_vld,
  input  wire ede_pkg::token_t    in_tok,
  output logic                    out_vld,
  output ede_pkg::token_t         out_tok
);

  localparam logic [ede_pkg::DIST_W-1:0] RST_VAL = ede_pkg::DIST_W'(IDX);

  logic                       vld_r;
  ede_pkg::token_t            tok_r;
  logic [ede_pkg::DIST_W-1:0] d_r;
  logic [ede_pkg::CHAR_W-1:0] ref_r;
  logic [ede_pkg::DIST_W-1:0] sub;
  logic [ede_pkg::DIST_W-1:0] up1;
  logic [ede_pkg::DIST_W-1:0] lf1;
  logic [ede_pkg::DIST_W-1:0] best;
  ede_pkg::token_t            tok_nxt;

  always_comb begin
    sub = (ref_r == in_tok.ch) ? in_tok.diag : ede_pkg::sat_inc(in_tok.diag);
    up1 = ede_pkg::sat_inc(d_r);
    lf1 = ede_pkg::sat_inc(in_tok.left);
    best = sub;
    if (up1 < best) begin
      best = up1;
    end
    if (lf1 < best) begin
      best = lf1;
    end
    tok_nxt.last = in_tok.last;
    tok_nxt.ch = in_tok.ch;
    tok_nxt.left = best;
    tok_nxt.diag = d_r;
    tok_nxt.res = (ref_len == LW'(IDX)) ? best : in_tok.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      d_r <= RST_VAL;
    end else begin
      if (ctl.adv) begin
        vld_r <= in_vld;
      end
      if (ctl.restart) begin
        d_r <= RST_VAL;
      end else if (ctl.adv && in_vld) begin
        d_r <= in_tok.last ? RST_VAL : best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tok_r <= tok_nxt;
    end
    if (ctl.wr && (ref_len == LW'(IDX - 1))) begin
      ref_r <= ctl.wr_char;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule
`default_nettype wire

FILE: design/edit_distance_engine.sv
// Query bytes enter one per cycle unless stalled, through a row of one cell per reference position.
// A result passes the head, each cell in turn and the output register after the query byte marked last.
// Clear and append transfers wait until the cell row holds no query bytes (up to MAX_REF_LEN + 1).
// A stalled result stops the whole row until it is taken.
// Synchronous reset empties the reference, clears the overflow flag and restarts the row.
`default_nettype none
module edit_distance_engine #(
  parameter int MAX_REF_LEN = ede_pkg::MAX_REF_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ede_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ede_pkg::out_item_t     out_data
);

  localparam int LW = $clog2(MAX_REF_LEN + 1);

  logic                      adv;
  logic                      busy;
  logic                      accept;
  logic                      full;
  logic                      q_vld;
  logic                      do_clear;
  logic                      do_append;
  ede_pkg::cell_ctl_t        ctl;
  logic [LW-1:0]             ref_len_r;
  logic [LW-1:0]             ref_len_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      out_valid_r;
  ede_pkg::out_item_t        out_data_r;
  logic [MAX_REF_LEN:0]      vld;
  ede_pkg::token_t           tok [MAX_REF_LEN+1];

  assign adv = !out_valid_r || !out_stall;
  assign busy = |vld;
  assign in_stall = !adv || (busy && (in_data.action != ede_pkg::ACT_QUERY));
  assign accept = in_valid && !in_stall;
  assign full = (ref_len_r == LW'(MAX_REF_LEN));

  always_comb begin
    q_vld = 1'b0;
    do_clear = 1'b0;
    do_append = 1'b0;
    unique case (in_data.action)
      ede_pkg::ACT_CLEAR: begin
        do_clear = accept;
      end
      ede_pkg::ACT_APPEND: begin
        do_append = accept;
      end
      ede_pkg::ACT_QUERY: begin
        q_vld = accept;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ref_len_nxt = ref_len_r;
    ovf_nxt = ovf_r;
    if (do_clear) begin
      ref_len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (do_append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        ref_len_nxt = ref_len_r + LW'(1);
      end
    end
  end

  always_comb begin
    ctl.adv = adv;
    ctl.restart = do_clear || do_append;
    ctl.wr = do_append && !full;
    ctl.wr_char = in_data.char_value;
  end

  ede_head #(
    .LW(LW)
  ) u_head (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .q_vld  (q_vld),
    .q_ch   (in_data.char_value),
    .q_last (in_data.is_last),
    .ref_len(ref_len_r),
    .out_vld(vld[0]),
    .out_tok(tok[0])
  );

  for (genvar j = 1; j <= MAX_REF_LEN; j++) begin : g_cell
    ede_cell #(
      .IDX(j),
      .LW (LW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .ref_len(ref_len_r),
      .in_vld (vld[j-1]),
      .in_tok (tok[j-1]),
      .out_vld(vld[j]),
      .out_tok(tok[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ref_len_r <= ref_len_nxt;
      ovf_r <= ovf_nxt;
      if (adv) begin
        out_valid_r <= vld[MAX_REF_LEN] && tok[MAX_REF_LEN].last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.distance <= tok[MAX_REF_LEN].res;
      out_data_r.ref_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire
